FILE: rtl/core/tlqs_pkg.sv
// thick line quad setup: shared widths, codes, sideband struct and saturation
// depends on nothing; used by every module of the block
package tlqs_pkg;

	localparam int COORD_BITS = 16;
	localparam int DIFF_BITS  = COORD_BITS + 1;
	localparam int MAG_BITS   = COORD_BITS;
	localparam int WID_BITS   = 12;
	localparam int COL_BITS   = 32;
	localparam int NORM_BITS  = 31;
	localparam int RAD_BITS   = 64;
	localparam int LEN_BITS   = 32;
	localparam int NUM_BITS   = 44;
	localparam int DEN_BITS   = LEN_BITS + 1;
	localparam int QUO_BITS   = 28;
	localparam int OFF_BITS   = QUO_BITS + 1;
	localparam int SUM_BITS   = QUO_BITS + 2;

	typedef enum logic {OP_RECT = 1'b0, OP_PARA = 1'b1} op_t;
	typedef enum logic {ST_OK = 1'b0, ST_HORIZ = 1'b1} status_t;

	// everything an item carries alongside the length and divide datapath
	typedef struct packed {
		logic                         err;
		logic                         para;
		logic                         horiz;
		logic                         neg;
		logic signed [COORD_BITS-1:0] xa;
		logic signed [COORD_BITS-1:0] ya;
		logic signed [COORD_BITS-1:0] xb;
		logic signed [COORD_BITS-1:0] yb;
		logic [WID_BITS-1:0]          w;
		logic [COL_BITS-1:0]          color;
		logic [NORM_BITS-1:0]         nx;
		logic [NORM_BITS-1:0]         ny;
	} side_t;

	function automatic logic signed [COORD_BITS-1:0] sat(input logic signed [SUM_BITS-1:0] v);
		logic signed [SUM_BITS-1:0] hi;
		logic signed [SUM_BITS-1:0] lo;
		hi = SUM_BITS'((64'sd1 <<< (COORD_BITS - 1)) - 64'sd1);
		lo = -hi - SUM_BITS'(1);
		if (v > hi) return hi[COORD_BITS-1:0];
		else if (v < lo) return lo[COORD_BITS-1:0];
		else return v[COORD_BITS-1:0];
	endfunction

endpackage

FILE: rtl/core/tlqs_sqrt.sv
// pipelined integer square root, two result bits per stage, sixteen stages
// depends on tlqs_pkg
module tlqs_sqrt (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               in_vld,
	input  tlqs_pkg::side_t                    in_side,
	input  logic [tlqs_pkg::RAD_BITS-1:0]      rad,
	output logic                               out_vld,
	output tlqs_pkg::side_t                    out_side,
	output logic [tlqs_pkg::LEN_BITS-1:0]      root
);
	localparam int NST = tlqs_pkg::RAD_BITS / 4;

	logic [tlqs_pkg::RAD_BITS-1:0] rem_s  [0:NST];
	logic [tlqs_pkg::RAD_BITS-1:0] root_s [0:NST];
	logic                          vld_s  [0:NST];
	tlqs_pkg::side_t               side_s [0:NST];

	assign rem_s[0]  = rad;
	assign root_s[0] = '0;
	assign vld_s[0]  = in_vld;
	assign side_s[0] = in_side;

	for (genvar g = 0; g < NST; g++) begin : g_st
		localparam logic [tlqs_pkg::RAD_BITS-1:0] BIT_A = 64'd1 << (62 - 4 * g);
		localparam logic [tlqs_pkg::RAD_BITS-1:0] BIT_B = 64'd1 << (60 - 4 * g);
		logic [tlqs_pkg::RAD_BITS-1:0] s_a, r_a, s_b, r_b;

		always_comb begin
			if (rem_s[g] >= root_s[g] + BIT_A) begin
				s_a = rem_s[g] - (root_s[g] + BIT_A);
				r_a = (root_s[g] >> 1) + BIT_A;
			end else begin
				s_a = rem_s[g];
				r_a = root_s[g] >> 1;
			end
			if (s_a >= r_a + BIT_B) begin
				s_b = s_a - (r_a + BIT_B);
				r_b = (r_a >> 1) + BIT_B;
			end else begin
				s_b = s_a;
				r_b = r_a >> 1;
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) vld_s[g+1] <= 1'b0;
			else vld_s[g+1] <= vld_s[g];
		end

		always_ff @(posedge clk) begin
			rem_s[g+1]  <= s_b;
			root_s[g+1] <= r_b;
			side_s[g+1] <= side_s[g];
		end
	end

	assign out_vld  = vld_s[NST];
	assign out_side = side_s[NST];
	assign root     = root_s[NST][tlqs_pkg::LEN_BITS-1:0];

endmodule

FILE: rtl/core/tlqs_div.sv
// pipelined restoring divider, two lanes side by side, two quotient bits per stage
// depends on tlqs_pkg
module tlqs_div (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               in_vld,
	input  tlqs_pkg::side_t                    in_side,
	input  logic [tlqs_pkg::NUM_BITS-1:0]      num_a,
	input  logic [tlqs_pkg::DEN_BITS-1:0]      den_a,
	input  logic [tlqs_pkg::NUM_BITS-1:0]      num_b,
	input  logic [tlqs_pkg::DEN_BITS-1:0]      den_b,
	output logic                               out_vld,
	output tlqs_pkg::side_t                    out_side,
	output logic [tlqs_pkg::QUO_BITS-1:0]      quo_a,
	output logic [tlqs_pkg::QUO_BITS-1:0]      quo_b
);
	localparam int NST = tlqs_pkg::QUO_BITS / 2;
	localparam int CW  = tlqs_pkg::DEN_BITS + tlqs_pkg::QUO_BITS - 1;

	function automatic logic [tlqs_pkg::NUM_BITS:0] div_step(
		input logic [tlqs_pkg::NUM_BITS-1:0] r,
		input logic [tlqs_pkg::DEN_BITS-1:0] d,
		input int sh
	);
		logic [CW-1:0] rx;
		logic [CW-1:0] dx;
		rx = CW'(r);
		dx = CW'(d) << sh;
		if (rx >= dx) return {1'b1, tlqs_pkg::NUM_BITS'(rx - dx)};
		else return {1'b0, r};
	endfunction

	logic [tlqs_pkg::NUM_BITS-1:0] ra_s [0:NST];
	logic [tlqs_pkg::NUM_BITS-1:0] rb_s [0:NST];
	logic [tlqs_pkg::DEN_BITS-1:0] da_s [0:NST];
	logic [tlqs_pkg::DEN_BITS-1:0] db_s [0:NST];
	logic [tlqs_pkg::QUO_BITS-1:0] qa_s [0:NST];
	logic [tlqs_pkg::QUO_BITS-1:0] qb_s [0:NST];
	logic                          vld_s  [0:NST];
	tlqs_pkg::side_t               side_s [0:NST];

	assign ra_s[0]   = num_a;
	assign rb_s[0]   = num_b;
	assign da_s[0]   = den_a;
	assign db_s[0]   = den_b;
	assign qa_s[0]   = '0;
	assign qb_s[0]   = '0;
	assign vld_s[0]  = in_vld;
	assign side_s[0] = in_side;

	for (genvar g = 0; g < NST; g++) begin : g_st
		localparam int SH_HI = tlqs_pkg::QUO_BITS - 1 - 2 * g;
		localparam int SH_LO = SH_HI - 1;
		logic [tlqs_pkg::NUM_BITS:0] a1, a2, b1, b2;

		always_comb begin
			a1 = div_step(ra_s[g], da_s[g], SH_HI);
			a2 = div_step(a1[tlqs_pkg::NUM_BITS-1:0], da_s[g], SH_LO);
			b1 = div_step(rb_s[g], db_s[g], SH_HI);
			b2 = div_step(b1[tlqs_pkg::NUM_BITS-1:0], db_s[g], SH_LO);
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) vld_s[g+1] <= 1'b0;
			else vld_s[g+1] <= vld_s[g];
		end

		always_ff @(posedge clk) begin
			ra_s[g+1]   <= a2[tlqs_pkg::NUM_BITS-1:0];
			rb_s[g+1]   <= b2[tlqs_pkg::NUM_BITS-1:0];
			da_s[g+1]   <= da_s[g];
			db_s[g+1]   <= db_s[g];
			qa_s[g+1]   <= qa_s[g] | (tlqs_pkg::QUO_BITS'(a1[tlqs_pkg::NUM_BITS]) << SH_HI)
				| (tlqs_pkg::QUO_BITS'(a2[tlqs_pkg::NUM_BITS]) << SH_LO);
			qb_s[g+1]   <= qb_s[g] | (tlqs_pkg::QUO_BITS'(b1[tlqs_pkg::NUM_BITS]) << SH_HI)
				| (tlqs_pkg::QUO_BITS'(b2[tlqs_pkg::NUM_BITS]) << SH_LO);
			side_s[g+1] <= side_s[g];
		end
	end

	assign out_vld  = vld_s[NST];
	assign out_side = side_s[NST];
	assign quo_a    = qa_s[NST];
	assign quo_b    = qb_s[NST];

endmodule

FILE: rtl/core/thick_line_quad_setup.sv
// thick line to quad corners; a line gives four corner beats and a rejected
// horizontal line in mode 1 a single beat; busy holds off start after each
// four-beat line; the pipeline never stalls
// since the result side cannot hold off, pacing at start keeps the corner beats apart
// reset clears the pipeline valid bits, the pacing counter and the output strobe
// uses tlqs_pkg, tlqs_sqrt and tlqs_div
module thick_line_quad_setup (
	input  logic                                     clk,
	input  logic                                     arst_n,
	input  logic                                     start,
	output logic                                     busy,
	input  logic                                     op,
	input  logic signed [tlqs_pkg::COORD_BITS-1:0]   x_first,
	input  logic signed [tlqs_pkg::COORD_BITS-1:0]   y_first,
	input  logic signed [tlqs_pkg::COORD_BITS-1:0]   x_second,
	input  logic signed [tlqs_pkg::COORD_BITS-1:0]   y_second,
	input  logic [tlqs_pkg::WID_BITS-1:0]            line_width,
	input  logic [tlqs_pkg::COL_BITS-1:0]            color_in,
	output logic                                     done,
	output logic signed [tlqs_pkg::COORD_BITS-1:0]   vert_x,
	output logic signed [tlqs_pkg::COORD_BITS-1:0]   vert_y,
	output logic [tlqs_pkg::COL_BITS-1:0]            color_out,
	output logic [1:0]                               corner,
	output logic                                     last,
	output logic                                     status
);
	localparam int CB = tlqs_pkg::COORD_BITS;

	logic accept, reject_in;
	logic [1:0] gap_q;

	assign reject_in = (op == tlqs_pkg::OP_PARA) && (y_first == y_second);
	assign accept    = start && !busy;
	assign busy      = gap_q != 2'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) gap_q <= 2'd0;
		else if (accept && !reject_in) gap_q <= 2'd3;
		else if (gap_q != 2'd0) gap_q <= gap_q - 2'd1;
	end

	// stage 1: differences, magnitudes, endpoint order
	logic signed [tlqs_pkg::DIFF_BITS-1:0] dx, dy;
	logic [tlqs_pkg::DIFF_BITS-1:0] adx, ady;
	logic horiz_in, swap_in;
	assign dx       = tlqs_pkg::DIFF_BITS'(x_second) - tlqs_pkg::DIFF_BITS'(x_first);
	assign dy       = tlqs_pkg::DIFF_BITS'(y_first) - tlqs_pkg::DIFF_BITS'(y_second);
	assign adx      = dx[tlqs_pkg::DIFF_BITS-1] ? -dx : dx;
	assign ady      = dy[tlqs_pkg::DIFF_BITS-1] ? -dy : dy;
	assign horiz_in = dy == '0;
	assign swap_in  = horiz_in ? (x_second < x_first) : (y_first < y_second);

	logic v_s1;
	tlqs_pkg::side_t side_s1;
	logic [tlqs_pkg::MAG_BITS-1:0] ax_s1, ay_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s1 <= 1'b0;
		else v_s1 <= accept;
	end

	always_ff @(posedge clk) begin
		side_s1.err   <= reject_in;
		side_s1.para  <= op;
		side_s1.horiz <= horiz_in;
		side_s1.neg   <= dx[tlqs_pkg::DIFF_BITS-1] != dy[tlqs_pkg::DIFF_BITS-1];
		side_s1.xa    <= swap_in ? x_second : x_first;
		side_s1.ya    <= swap_in ? y_second : y_first;
		side_s1.xb    <= swap_in ? x_first : x_second;
		side_s1.yb    <= swap_in ? y_first : y_second;
		side_s1.w     <= line_width;
		side_s1.color <= color_in;
		side_s1.nx    <= '0;
		side_s1.ny    <= '0;
		ax_s1         <= adx[tlqs_pkg::MAG_BITS-1:0];
		ay_s1         <= ady[tlqs_pkg::MAG_BITS-1:0];
	end

	// stage 2: normalizing shift from the leading one of either magnitude
	logic [tlqs_pkg::MAG_BITS-1:0] any_mag;
	logic [3:0] msb;
	assign any_mag = ax_s1 | ay_s1;
	always_comb begin
		msb = 4'd0;
		for (int i = 0; i < tlqs_pkg::MAG_BITS; i++) begin
			if (any_mag[i]) msb = 4'(i);
		end
	end

	logic v_s2;
	tlqs_pkg::side_t side_s2;
	logic [tlqs_pkg::MAG_BITS-1:0] ax_s2, ay_s2;
	logic [4:0] sh_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s2 <= 1'b0;
		else v_s2 <= v_s1;
	end

	always_ff @(posedge clk) begin
		side_s2 <= side_s1;
		ax_s2   <= ax_s1;
		ay_s2   <= ay_s1;
		sh_s2   <= 5'd30 - {1'b0, msb};
	end

	// stage 3: shift both magnitudes so the larger sits in [2^30, 2^31)
	logic v_s3;
	tlqs_pkg::side_t side_s3, side_n3;

	always_comb begin
		side_n3    = side_s2;
		side_n3.nx = tlqs_pkg::NORM_BITS'(ax_s2) << sh_s2;
		side_n3.ny = tlqs_pkg::NORM_BITS'(ay_s2) << sh_s2;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s3 <= 1'b0;
		else v_s3 <= v_s2;
	end

	always_ff @(posedge clk) begin
		side_s3 <= side_n3;
	end

	// stage 4: squares; stage 5: radicand
	logic v_s4, v_s5;
	tlqs_pkg::side_t side_s4, side_s5;
	logic [2*tlqs_pkg::NORM_BITS-1:0] sqx_s4, sqy_s4;
	logic [tlqs_pkg::RAD_BITS-1:0] rad_s5;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else begin
			v_s4 <= v_s3;
			v_s5 <= v_s4;
		end
	end

	always_ff @(posedge clk) begin
		side_s4 <= side_s3;
		sqx_s4  <= side_s3.nx * side_s3.nx;
		sqy_s4  <= side_s3.ny * side_s3.ny;
		side_s5 <= side_s4;
		rad_s5  <= tlqs_pkg::RAD_BITS'(sqx_s4) + tlqs_pkg::RAD_BITS'(sqy_s4);
	end

	logic sq_vld;
	tlqs_pkg::side_t sq_side;
	logic [tlqs_pkg::LEN_BITS-1:0] len;

	tlqs_sqrt u_sqrt (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_vld   (v_s5),
		.in_side  (side_s5),
		.rad      (rad_s5),
		.out_vld  (sq_vld),
		.out_side (sq_side),
		.root     (len)
	);

	// stage 6: products with the width; stage 7: rounded dividends and divisors
	logic v_s6, v_s7;
	tlqs_pkg::side_t side_s6, side_s7;
	logic [tlqs_pkg::NUM_BITS-1:0] pa_s6, pb_s6;
	logic [tlqs_pkg::LEN_BITS-1:0] len_s6;
	logic [tlqs_pkg::NUM_BITS-1:0] na_s7, nb_s7;
	logic [tlqs_pkg::DEN_BITS-1:0] da_s7, db_s7;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s6 <= 1'b0;
			v_s7 <= 1'b0;
		end else begin
			v_s6 <= sq_vld;
			v_s7 <= v_s6;
		end
	end

	always_ff @(posedge clk) begin
		side_s6 <= sq_side;
		len_s6  <= len;
		pa_s6   <= tlqs_pkg::NUM_BITS'(sq_side.w)
			* tlqs_pkg::NUM_BITS'(sq_side.para ? len : tlqs_pkg::LEN_BITS'(sq_side.ny));
		pb_s6   <= tlqs_pkg::NUM_BITS'(sq_side.w) * tlqs_pkg::NUM_BITS'(sq_side.nx);
		side_s7 <= side_s6;
		if (side_s6.para) begin
			na_s7 <= pa_s6 + tlqs_pkg::NUM_BITS'(side_s6.ny);
			da_s7 <= tlqs_pkg::DEN_BITS'({side_s6.ny, 1'b0});
		end else begin
			na_s7 <= pa_s6 + tlqs_pkg::NUM_BITS'(len_s6);
			da_s7 <= {len_s6, 1'b0};
		end
		nb_s7 <= pb_s6 + tlqs_pkg::NUM_BITS'(len_s6);
		db_s7 <= {len_s6, 1'b0};
	end

	logic dv_vld;
	tlqs_pkg::side_t dv_side;
	logic [tlqs_pkg::QUO_BITS-1:0] qa, qb;

	tlqs_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_vld   (v_s7),
		.in_side  (side_s7),
		.num_a    (na_s7),
		.den_a    (da_s7),
		.num_b    (nb_s7),
		.den_b    (db_s7),
		.out_vld  (dv_vld),
		.out_side (dv_side),
		.quo_a    (qa),
		.quo_b    (qb)
	);

	// stage 8: signed offsets
	logic v_s8;
	tlqs_pkg::side_t side_s8;
	logic signed [tlqs_pkg::OFF_BITS-1:0] ox_s8, oy_s8;
	logic [tlqs_pkg::WID_BITS:0] wp1;
	logic signed [tlqs_pkg::OFF_BITS-1:0] qa_ext, qb_ext;
	assign wp1    = {1'b0, dv_side.w} + (tlqs_pkg::WID_BITS + 1)'(1);
	assign qa_ext = $signed({1'b0, qa});
	assign qb_ext = $signed({1'b0, qb});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s8 <= 1'b0;
		else v_s8 <= dv_vld;
	end

	always_ff @(posedge clk) begin
		side_s8 <= dv_side;
		if (dv_side.horiz) begin
			ox_s8 <= '0;
			oy_s8 <= tlqs_pkg::OFF_BITS'(wp1[tlqs_pkg::WID_BITS:1]);
		end else if (dv_side.para) begin
			ox_s8 <= qa_ext;
			oy_s8 <= '0;
		end else begin
			ox_s8 <= qa_ext;
			oy_s8 <= dv_side.neg ? -qb_ext : qb_ext;
		end
	end

	// stage 9: corners, saturated
	logic signed [tlqs_pkg::SUM_BITS-1:0] xa_e, ya_e, xb_e, yb_e, ox_e, oy_e;
	assign xa_e = tlqs_pkg::SUM_BITS'(side_s8.xa);
	assign ya_e = tlqs_pkg::SUM_BITS'(side_s8.ya);
	assign xb_e = tlqs_pkg::SUM_BITS'(side_s8.xb);
	assign yb_e = tlqs_pkg::SUM_BITS'(side_s8.yb);
	assign ox_e = tlqs_pkg::SUM_BITS'(ox_s8);
	assign oy_e = tlqs_pkg::SUM_BITS'(oy_s8);

	logic v_s9, err_s9;
	logic [tlqs_pkg::COL_BITS-1:0] col_s9;
	logic signed [CB-1:0] cx_s9 [0:3];
	logic signed [CB-1:0] cy_s9 [0:3];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s9 <= 1'b0;
		else v_s9 <= v_s8;
	end

	always_ff @(posedge clk) begin
		err_s9   <= side_s8.err;
		col_s9   <= side_s8.color;
		cx_s9[0] <= tlqs_pkg::sat(xa_e - ox_e);
		cy_s9[0] <= tlqs_pkg::sat(ya_e - oy_e);
		cx_s9[1] <= tlqs_pkg::sat(xb_e - ox_e);
		cy_s9[1] <= tlqs_pkg::sat(yb_e - oy_e);
		cx_s9[2] <= tlqs_pkg::sat(xa_e + ox_e);
		cy_s9[2] <= tlqs_pkg::sat(ya_e + oy_e);
		cx_s9[3] <= tlqs_pkg::sat(xb_e + ox_e);
		cy_s9[3] <= tlqs_pkg::sat(yb_e + oy_e);
	end

	// corner serializer: one beat a cycle
	logic act_q, done_q, last_q;
	logic [1:0] cnt_q, corner_q;
	tlqs_pkg::status_t status_q;
	logic signed [CB-1:0] hx_q [1:3];
	logic signed [CB-1:0] hy_q [1:3];
	logic [tlqs_pkg::COL_BITS-1:0] col_q;
	logic signed [CB-1:0] vx_q, vy_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			act_q    <= 1'b0;
			done_q   <= 1'b0;
			cnt_q    <= 2'd0;
			corner_q <= 2'd0;
			last_q   <= 1'b0;
			status_q <= tlqs_pkg::ST_OK;
		end else if (v_s9) begin
			done_q   <= 1'b1;
			corner_q <= 2'd0;
			last_q   <= err_s9;
			status_q <= err_s9 ? tlqs_pkg::ST_HORIZ : tlqs_pkg::ST_OK;
			act_q    <= !err_s9;
			cnt_q    <= 2'd1;
		end else if (act_q) begin
			done_q   <= 1'b1;
			corner_q <= cnt_q;
			last_q   <= cnt_q == 2'd3;
			status_q <= tlqs_pkg::ST_OK;
			act_q    <= cnt_q != 2'd3;
			cnt_q    <= cnt_q + 2'd1;
		end else begin
			done_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (v_s9) begin
			col_q <= col_s9;
			for (int i = 1; i < 4; i++) begin
				hx_q[i] <= cx_s9[i];
				hy_q[i] <= cy_s9[i];
			end
			vx_q <= err_s9 ? '0 : cx_s9[0];
			vy_q <= err_s9 ? '0 : cy_s9[0];
		end else if (act_q) begin
			case (cnt_q)
				2'd1: begin
					vx_q <= hx_q[1];
					vy_q <= hy_q[1];
				end
				2'd2: begin
					vx_q <= hx_q[2];
					vy_q <= hy_q[2];
				end
				default: begin
					vx_q <= hx_q[3];
					vy_q <= hy_q[3];
				end
			endcase
		end
	end

	assign done      = done_q;
	assign vert_x    = vx_q;
	assign vert_y    = vy_q;
	assign color_out = col_q;
	assign corner    = corner_q;
	assign last      = last_q;
	assign status    = status_q;

	// a four-beat line must be paced at the input
	a_pace: assert property (@(posedge clk) disable iff (!arst_n)
		accept && !reject_in |=> busy)
		else $error("no pacing after a four-beat line");

	// pacing keeps a new arrival off a burst in flight
	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		act_q |-> !v_s9)
		else $error("line arrived while corners still serializing");

	// corners of one line come out back to back in order
	a_order: assert property (@(posedge clk) disable iff (!arst_n)
		done && corner != 2'd0 |-> $past(done) && corner == $past(corner) + 2'd1)
		else $error("corner beats out of order");

	// a rejected line is a single beat
	a_reject: assert property (@(posedge clk) disable iff (!arst_n)
		done && status |-> last && corner == 2'd0)
		else $error("reject beat malformed");

endmodule

FILE: tb/sv/tb_thick_line_quad_setup.sv
// self-checking testbench for thick_line_quad_setup: random and directed line items,
// corner beats predicted in-bench and compared in order; depends on tlqs_pkg and the rtl
`timescale 1ns / 1ps

module tb_thick_line_quad_setup;

	typedef struct packed {
		logic        op;
		logic [15:0] xa;
		logic [15:0] ya;
		logic [15:0] xb;
		logic [15:0] yb;
		logic [11:0] w;
		logic [31:0] color;
	} line_item_t;

	typedef struct packed {
		logic [15:0] vx;
		logic [15:0] vy;
		logic [31:0] color;
		logic [1:0]  idx;
		logic        last;
		logic        status;
	} corner_beat_t;

	logic        clk;
	logic        arst_n;
	logic        start;
	logic        busy;
	logic        op;
	logic signed [15:0] x_first, y_first, x_second, y_second;
	logic [11:0] line_width;
	logic [31:0] color_in;
	logic        done;
	logic signed [15:0] vert_x, vert_y;
	logic [31:0] color_out;
	logic [1:0]  corner;
	logic        last;
	logic        status;

	line_item_t   pending_lines[$];
	corner_beat_t expected_corners[$];
	int           errors;
	bit           feed_done;
	bit           calm;

	thick_line_quad_setup u_dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .op(op),
		.x_first(x_first), .y_first(y_first), .x_second(x_second), .y_second(y_second),
		.line_width(line_width), .color_in(color_in), .done(done),
		.vert_x(vert_x), .vert_y(vert_y), .color_out(color_out), .corner(corner),
		.last(last), .status(status)
	);

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	function automatic logic [15:0] clamp16(input longint v);
		if (v > 32767) return 16'h7fff;
		if (v < -32768) return 16'h8000;
		return v[15:0];
	endfunction

	function automatic longint unsigned int_sqrt(input longint unsigned s);
		longint unsigned r, b;
		r = 0;
		b = 64'd1 << 62;
		while (b > s) b >>= 2;
		while (b != 0) begin
			if (s >= r + b) begin
				s -= r + b;
				r = (r >> 1) + b;
			end else begin
				r >>= 1;
			end
			b >>= 2;
		end
		return r;
	endfunction

	task automatic predict_corners(input line_item_t it);
		longint x1, y1, x2, y2, dx, dy, ox, oy, t;
		longint unsigned ax, ay, len, w, m;
		corner_beat_t cb;
		x1 = longint'($signed(it.xa));
		y1 = longint'($signed(it.ya));
		x2 = longint'($signed(it.xb));
		y2 = longint'($signed(it.yb));
		w = 64'(it.w);
		dx = x2 - x1;
		dy = y1 - y2;
		ox = 0;
		oy = 0;
		if (dy == 0 && tlqs_pkg::op_t'(it.op) == tlqs_pkg::OP_PARA) begin
			cb = '{16'd0, 16'd0, it.color, 2'd0, 1'b1, tlqs_pkg::ST_HORIZ};
			expected_corners.push_back(cb);
			return;
		end
		if (dy == 0) begin
			oy = longint'((w + 1) >> 1);
			if (x2 < x1) begin
				t = x1; x1 = x2; x2 = t;
				t = y1; y1 = y2; y2 = t;
			end
		end else begin
			ax = (dx < 0) ? -dx : dx;
			ay = (dy < 0) ? -dy : dy;
			while (ax >= (64'd1 << 31) || ay >= (64'd1 << 31)) begin
				ax >>= 1;
				ay >>= 1;
			end
			while (ax < (64'd1 << 30) && ay < (64'd1 << 30)) begin
				ax <<= 1;
				ay <<= 1;
			end
			len = int_sqrt(ax * ax + ay * ay);
			if (tlqs_pkg::op_t'(it.op) == tlqs_pkg::OP_RECT) begin
				ox = longint'((w * ay + len) / (2 * len));
				m = (w * ax + len) / (2 * len);
				oy = ((dx < 0) != (dy < 0)) ? -longint'(m) : longint'(m);
			end else if (ay == 0) begin
				ox = longint'(w << 32);
			end else begin
				ox = longint'((w * len + ay) / (2 * ay));
			end
			if (y1 < y2) begin
				t = x1; x1 = x2; x2 = t;
				t = y1; y1 = y2; y2 = t;
			end
		end
		expected_corners.push_back('{clamp16(x1 - ox), clamp16(y1 - oy), it.color,
			2'd0, 1'b0, tlqs_pkg::ST_OK});
		expected_corners.push_back('{clamp16(x2 - ox), clamp16(y2 - oy), it.color,
			2'd1, 1'b0, tlqs_pkg::ST_OK});
		expected_corners.push_back('{clamp16(x1 + ox), clamp16(y1 + oy), it.color,
			2'd2, 1'b0, tlqs_pkg::ST_OK});
		expected_corners.push_back('{clamp16(x2 + ox), clamp16(y2 + oy), it.color,
			2'd3, 1'b1, tlqs_pkg::ST_OK});
	endtask

	function automatic line_item_t rand_line();
		line_item_t it;
		logic [15:0] span;
		it.op = 1'($urandom_range(0, 1));
		it.color = $urandom;
		it.w = ($urandom_range(0, 9) == 0) ? 12'hfff : 12'($urandom_range(0, 4095));
		it.xa = 16'($urandom);
		it.ya = 16'($urandom);
		case ($urandom_range(0, 5))
			0: begin
				it.xb = 16'($urandom);
				it.yb = 16'($urandom);
			end
			1: begin
				it.xb = 16'($urandom);
				it.yb = it.ya;
			end
			2: begin
				// nearly horizontal segments; the next case makes nearly vertical ones
				it.xb = 16'($urandom);
				it.yb = it.ya + 16'($urandom_range(0, 2)) - 16'd1;
			end
			3: begin
				it.xb = it.xa + 16'($urandom_range(0, 2)) - 16'd1;
				it.yb = 16'($urandom);
			end
			default: begin
				span = 16'($urandom_range(0, 2047));
				it.xb = it.xa + span - 16'd1024;
				span = 16'($urandom_range(0, 2047));
				it.yb = it.ya + span - 16'd1024;
			end
		endcase
		return it;
	endfunction

	initial begin
		errors = 0;
		feed_done = 0;
		start = 0;
		op = 0;
		x_first = 0;
		y_first = 0;
		x_second = 0;
		y_second = 0;
		line_width = 0;
		color_in = 0;
		arst_n = 0;
		// directed: extremes, both modes, horizontal, vertical, tiny dy
		pending_lines.push_back('{tlqs_pkg::OP_RECT, 16'h0000, 16'h0000, 16'h0100, 16'h0000,
			12'h010, 32'h0});
		pending_lines.push_back('{tlqs_pkg::OP_RECT, 16'h0100, 16'h0000, 16'h0000, 16'h0000,
			12'hfff, 32'hffffffff});
		pending_lines.push_back('{tlqs_pkg::OP_PARA, 16'h0000, 16'h0050, 16'h0100, 16'h0050,
			12'h020, 32'h12345678});
		pending_lines.push_back('{tlqs_pkg::OP_RECT, 16'h0000, 16'h0000, 16'h0000, 16'h0100,
			12'h020, 32'hdeadbeef});
		pending_lines.push_back('{tlqs_pkg::OP_PARA, 16'h0000, 16'h0000, 16'h0000, 16'h0100,
			12'h020, 32'h0f0f0f0f});
		pending_lines.push_back('{tlqs_pkg::OP_RECT, 16'h8000, 16'h8000, 16'h7fff, 16'h7fff,
			12'hfff, 32'haaaaaaaa});
		pending_lines.push_back('{tlqs_pkg::OP_PARA, 16'h8000, 16'h8000, 16'h7fff, 16'h7fff,
			12'hfff, 32'h55555555});
		pending_lines.push_back('{tlqs_pkg::OP_PARA, 16'h8000, 16'h0000, 16'h7fff, 16'h0001,
			12'hfff, 32'h1});
		pending_lines.push_back('{tlqs_pkg::OP_PARA, 16'h8000, 16'h0000, 16'h7fff, 16'h0001,
			12'h000, 32'h2});
		pending_lines.push_back('{tlqs_pkg::OP_RECT, 16'h7fff, 16'h8000, 16'h8000, 16'h7fff,
			12'h001, 32'h3});
		pending_lines.push_back('{tlqs_pkg::OP_RECT, 16'h0010, 16'h0020, 16'h0030, 16'h0040,
			12'h000, 32'h4});
		pending_lines.push_back('{tlqs_pkg::OP_RECT, 16'h0000, 16'h0000, 16'h0000, 16'h0000,
			12'h030, 32'h5});
		pending_lines.push_back('{tlqs_pkg::OP_PARA, 16'h0000, 16'h0000, 16'h0000, 16'h0000,
			12'h030, 32'h6});
		pending_lines.push_back('{tlqs_pkg::OP_RECT, 16'h0030, 16'h0040, 16'h0010, 16'h0020,
			12'h7ff, 32'h7});
		pending_lines.push_back('{tlqs_pkg::OP_PARA, 16'h0030, 16'h0040, 16'h0010, 16'h0020,
			12'h7ff, 32'h8});
		repeat (440) pending_lines.push_back(rand_line());
		repeat (7) @(posedge clk);
		arst_n <= 1;
	end

	// long calm stretch in the middle of the run
	initial begin
		calm = 0;
		#(1500 * 10);
		calm = 1;
		#(600 * 10);
		calm = 0;
	end

	// driver
	always @(posedge clk) begin
		line_item_t it;
		if (arst_n) begin
			if (start && !busy) begin
				if (pending_lines.size() != 0 && (calm || $urandom_range(0, 99) >= 15)) begin
					it = pending_lines.pop_front();
					start <= 1;
					op <= it.op;
					x_first <= it.xa;
					y_first <= it.ya;
					x_second <= it.xb;
					y_second <= it.yb;
					line_width <= it.w;
					color_in <= it.color;
					predict_corners(it);
				end else begin
					start <= 0;
					if (pending_lines.size() == 0) feed_done <= 1;
				end
			end else if (!start) begin
				if (pending_lines.size() != 0 && (calm || $urandom_range(0, 99) >= 15)) begin
					it = pending_lines.pop_front();
					start <= 1;
					op <= it.op;
					x_first <= it.xa;
					y_first <= it.ya;
					x_second <= it.xb;
					y_second <= it.yb;
					line_width <= it.w;
					color_in <= it.color;
					predict_corners(it);
				end else if (pending_lines.size() == 0) begin
					feed_done <= 1;
				end
			end
		end
	end

	// monitor
	always @(posedge clk) begin
		corner_beat_t exp_c, got;
		if (arst_n && done) begin
			got = '{vert_x, vert_y, color_out, corner, last, status};
			if (expected_corners.size() == 0) begin
				$display("%0t: unexpected beat, actual %h", $time, got);
				errors++;
			end else begin
				exp_c = expected_corners.pop_front();
				if (got !== exp_c) begin
					$display({"%0t: mismatch x/y/color/corner/last/status expected ",
						"%h %h %h %0d %0d %0d actual %h %h %h %0d %0d %0d"},
						$time, exp_c.vx, exp_c.vy, exp_c.color, exp_c.idx,
						exp_c.last, exp_c.status,
						got.vx, got.vy, got.color, got.idx, got.last, got.status);
					errors++;
				end
			end
		end
	end

	initial begin
		wait (feed_done && !start);
		wait (expected_corners.size() == 0);
		repeat (60) @(posedge clk);
		if (errors == 0) begin
			$display("PASSED: all results match");
		end else begin
			$display("FAILED: results differ");
		end
		$finish;
	end

	initial begin
		#(200000 * 10);
		$display("FAILED: results differ");
		$finish;
	end

endmodule
